>>> rtl/itp_pkg.sv
// ============================================================================
// itp_pkg: shared types, constants and microcode for the converter
// Holds the transaction payload structs, the character classes, the control
// word layout and the read-only microprogram that the sequencer steps through.
// ============================================================================
package itp_pkg;

  localparam int LINE_LEN = 64;
  localparam int AW       = $clog2(LINE_LEN);
  localparam int CW       = $clog2(LINE_LEN + 1);
  localparam int STEP_W   = 5;

  typedef logic [AW-1:0]     addr_t;
  typedef logic [CW-1:0]     cnt_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam cnt_t LEN_MAX = cnt_t'(LINE_LEN);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  localparam logic [1:0] E_OK    = 2'd0;
  localparam logic [1:0] E_OPEN  = 2'd1;
  localparam logic [1:0] E_CLOSE = 2'd2;
  localparam logic [1:0] E_LONG  = 2'd3;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_out;
    logic       empty_res;
    logic [1:0] error;
  } out_t;

  typedef enum logic [3:0] {
    C_NEVER, C_NO_LAST, C_ERR, C_IDX_ZERO, C_IDX_NZ, C_SP_ZERO, C_LB_OPEN,
    C_LB_OP, C_LB_NOALNUM, C_LB_NOCLOSE, C_STK_CLOSE, C_NOT_HIGHER,
    C_OLEN_ZERO, C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {IDX_HOLD, IDX_LEN, IDX_DEC, IDX_OLEN} idx_op_t;
  typedef enum logic [1:0] {SP_HOLD, SP_DEC, SP_INC} sp_op_t;
  typedef enum logic [1:0] {EOP_HOLD, EOP_OPEN, EOP_CLOSE} err_op_t;
  typedef enum logic {EMIT_CH, EMIT_STK} emit_src_t;

  typedef struct packed {
    logic      in_rdy;
    logic      init;
    idx_op_t   idx_op;
    sp_op_t    sp_op;
    err_op_t   err_op;
    logic      lb_re;
    logic      stk_re;
    logic      stk_we;
    logic      ob_re;
    logic      ob_we;
    emit_src_t emit_src;
    logic      ch_ld;
    logic      put_ok;
    logic      put_err;
  } ctrl_t;

  typedef struct packed {
    cond_t cond;
    step_t jmp;
    step_t nxt;
    ctrl_t act;
  } uword_t;

  typedef struct packed {
    logic last_in;
    logic err_nz;
    logic idx_zero;
    logic sp_zero;
    logic lb_open;
    logic lb_op;
    logic lb_alnum;
    logic lb_close;
    logic stk_close;
    logic higher;
    logic olen_zero;
    logic out_busy;
  } flags_t;

  localparam step_t ST_LOAD  = 5'd0;
  localparam step_t ST_START = 5'd1;
  localparam step_t ST_CHK   = 5'd2;
  localparam step_t ST_FETCH = 5'd3;
  localparam step_t ST_D0    = 5'd4;
  localparam step_t ST_D1    = 5'd5;
  localparam step_t ST_D2    = 5'd6;
  localparam step_t ST_D3    = 5'd7;
  localparam step_t ST_P0    = 5'd8;
  localparam step_t ST_P1    = 5'd9;
  localparam step_t ST_O0    = 5'd10;
  localparam step_t ST_O1    = 5'd11;
  localparam step_t ST_OPUSH = 5'd12;
  localparam step_t ST_F0    = 5'd13;
  localparam step_t ST_F1    = 5'd14;
  localparam step_t ST_ERR1  = 5'd15;
  localparam step_t ST_ERR2  = 5'd16;
  localparam step_t ST_DONE  = 5'd17;
  localparam step_t ST_S0    = 5'd18;
  localparam step_t ST_S1    = 5'd19;
  localparam step_t ST_S2    = 5'd20;
  localparam step_t ST_ERR   = 5'd21;

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
           (c == CH_SLASH) || (c == CH_CARET);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [1:0] prec(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  // Actions apply only if the jump is not taken; in_rdy applies either way.
  function automatic uword_t ucode(input step_t st);
    uword_t w;
    w = '0;
    w.cond = C_NEVER;
    w.jmp = ST_LOAD;
    w.nxt = ST_LOAD;
    case (st)
      ST_LOAD: begin
        w.cond = C_NO_LAST; w.jmp = ST_LOAD; w.nxt = ST_START;
        w.act.in_rdy = 1'b1;
      end
      ST_START: begin
        w.nxt = ST_CHK; w.act.init = 1'b1; w.act.idx_op = IDX_LEN;
      end
      ST_CHK: begin
        w.cond = C_ERR; w.jmp = ST_ERR; w.nxt = ST_FETCH;
      end
      ST_FETCH: begin
        w.cond = C_IDX_ZERO; w.jmp = ST_F0; w.nxt = ST_D0;
        w.act.lb_re = 1'b1; w.act.idx_op = IDX_DEC;
      end
      ST_D0: begin
        w.cond = C_LB_OPEN; w.jmp = ST_P0; w.nxt = ST_D1; w.act.ch_ld = 1'b1;
      end
      ST_D1: begin
        w.cond = C_LB_OP; w.jmp = ST_O0; w.nxt = ST_D2;
      end
      ST_D2: begin
        w.cond = C_LB_NOALNUM; w.jmp = ST_D3; w.nxt = ST_FETCH;
        w.act.ob_we = 1'b1; w.act.emit_src = EMIT_CH;
      end
      ST_D3: begin
        w.cond = C_LB_NOCLOSE; w.jmp = ST_FETCH; w.nxt = ST_FETCH;
        w.act.stk_we = 1'b1; w.act.sp_op = SP_INC;
      end
      ST_P0: begin
        w.cond = C_SP_ZERO; w.jmp = ST_ERR1; w.nxt = ST_P1;
        w.act.stk_re = 1'b1; w.act.sp_op = SP_DEC;
      end
      ST_P1: begin
        w.cond = C_STK_CLOSE; w.jmp = ST_FETCH; w.nxt = ST_P0;
        w.act.ob_we = 1'b1; w.act.emit_src = EMIT_STK;
      end
      ST_O0: begin
        w.cond = C_SP_ZERO; w.jmp = ST_OPUSH; w.nxt = ST_O1;
        w.act.stk_re = 1'b1;
      end
      ST_O1: begin
        w.cond = C_NOT_HIGHER; w.jmp = ST_OPUSH; w.nxt = ST_O0;
        w.act.ob_we = 1'b1; w.act.emit_src = EMIT_STK; w.act.sp_op = SP_DEC;
      end
      ST_OPUSH: begin
        w.nxt = ST_FETCH; w.act.stk_we = 1'b1; w.act.sp_op = SP_INC;
      end
      ST_F0: begin
        w.cond = C_SP_ZERO; w.jmp = ST_DONE; w.nxt = ST_F1;
        w.act.stk_re = 1'b1; w.act.sp_op = SP_DEC;
      end
      ST_F1: begin
        w.cond = C_STK_CLOSE; w.jmp = ST_ERR2; w.nxt = ST_F0;
        w.act.ob_we = 1'b1; w.act.emit_src = EMIT_STK;
      end
      ST_ERR1: begin
        w.nxt = ST_ERR; w.act.err_op = EOP_OPEN;
      end
      ST_ERR2: begin
        w.nxt = ST_ERR; w.act.err_op = EOP_CLOSE;
      end
      ST_DONE: begin
        w.cond = C_OLEN_ZERO; w.jmp = ST_ERR; w.nxt = ST_S0;
        w.act.idx_op = IDX_OLEN;
      end
      ST_S0: begin
        w.nxt = ST_S1; w.act.ob_re = 1'b1; w.act.idx_op = IDX_DEC;
      end
      ST_S1: begin
        w.cond = C_OUT_BUSY; w.jmp = ST_S1; w.nxt = ST_S2; w.act.put_ok = 1'b1;
      end
      ST_S2: begin
        w.cond = C_IDX_NZ; w.jmp = ST_S0; w.nxt = ST_LOAD;
      end
      ST_ERR: begin
        w.cond = C_OUT_BUSY; w.jmp = ST_ERR; w.nxt = ST_LOAD;
        w.act.put_err = 1'b1;
      end
      default: begin
        w.nxt = ST_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/infix_to_prefix_converter_top.sv
// ============================================================================
// infix_to_prefix_converter_top: infix to prefix expression converter
// Loads one character per cycle; after the last one a microcoded sequencer
// scans the line from its end with an operator stack, then sends the prefix
// characters out one transaction each.
// Characters load at one per cycle while in_ready is high. After the last
// character the scan sets up, reads each character from the end and pops
// the stack as needed; then each result character goes out, held while
// out_ready is low, and an error or empty result goes out as one transaction.
// Only one expression is handled at a time; the next one loads once the
// final result is in the output register.
// Reset is synchronous, active low: the sequencer returns to the load step and
// all counters clear; buffer contents are left as they are.
// ============================================================================
module infix_to_prefix_converter_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  itp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output itp_pkg::out_t out_data
);

  itp_pkg::ctrl_t  ctrl;
  itp_pkg::flags_t flags;

  itp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  itp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .flags     (flags),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.is_last |=> !in_ready)
    else $error("input accepted right after the final character");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.last_out)
    else $error("empty result not marked as final");

  a_error_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.error != itp_pkg::E_OK) |-> out_data.empty_res)
    else $error("error result carries characters");

  a_no_load_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_out |-> !in_ready)
    else $error("input taken in the middle of a result sequence");

endmodule

>>> rtl/itp_ram.sv
// ============================================================================
// itp_ram: generic single-write, single-read RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/itp_seq.sv
// ============================================================================
// itp_seq: microcode sequencer
// Steps through the control store, evaluates the jump condition of each
// control word and hands its actions to the datapath.
// ============================================================================
module itp_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  itp_pkg::flags_t flags,
  output itp_pkg::ctrl_t  ctrl
);

  itp_pkg::step_t  pc_r;
  itp_pkg::step_t  pc_nxt;
  itp_pkg::uword_t uw;
  logic            taken;

  assign uw = itp_pkg::ucode(pc_r);

  always_comb begin
    case (uw.cond)
      itp_pkg::C_NEVER:      taken = 1'b0;
      itp_pkg::C_NO_LAST:    taken = !(flags.last_in && uw.act.in_rdy);
      itp_pkg::C_ERR:        taken = flags.err_nz;
      itp_pkg::C_IDX_ZERO:   taken = flags.idx_zero;
      itp_pkg::C_IDX_NZ:     taken = !flags.idx_zero;
      itp_pkg::C_SP_ZERO:    taken = flags.sp_zero;
      itp_pkg::C_LB_OPEN:    taken = flags.lb_open;
      itp_pkg::C_LB_OP:      taken = flags.lb_op;
      itp_pkg::C_LB_NOALNUM: taken = !flags.lb_alnum;
      itp_pkg::C_LB_NOCLOSE: taken = !flags.lb_close;
      itp_pkg::C_STK_CLOSE:  taken = flags.stk_close;
      itp_pkg::C_NOT_HIGHER: taken = !flags.higher;
      itp_pkg::C_OLEN_ZERO:  taken = flags.olen_zero;
      itp_pkg::C_OUT_BUSY:   taken = flags.out_busy;
      default:               taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt = taken ? uw.jmp : uw.nxt;
    ctrl = uw.act;
    if (taken) begin
      ctrl = '0;
      ctrl.in_rdy = uw.act.in_rdy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= itp_pkg::ST_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

>>> rtl/itp_dp.sv
// ============================================================================
// itp_dp: converter datapath
// Line buffer, operator stack and output buffer memories with their counters,
// the character classifier and the result register.
// ============================================================================
module itp_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  itp_pkg::ctrl_t  ctrl,
  output itp_pkg::flags_t flags,
  input  logic            in_valid,
  output logic            in_ready,
  input  itp_pkg::in_t    in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output itp_pkg::out_t   out_data
);

  itp_pkg::cnt_t  len_r, len_nxt;
  itp_pkg::cnt_t  idx_r, idx_nxt;
  itp_pkg::cnt_t  sp_r, sp_nxt;
  itp_pkg::cnt_t  olen_r, olen_nxt;
  logic           ovf_r, ovf_nxt;
  logic [7:0]     ch_r, ch_nxt;
  logic [1:0]     err_r, err_nxt;
  logic           out_valid_r, out_valid_nxt;
  itp_pkg::out_t  out_data_r, out_data_nxt;

  itp_pkg::cnt_t  idx_dec;
  itp_pkg::cnt_t  sp_dec;
  logic           in_acc;
  logic           lb_we;
  logic           stk_push;
  logic           ob_push;
  logic [7:0]     lb_rdata;
  logic [7:0]     stk_rdata;
  logic [7:0]     ob_rdata;
  logic [7:0]     emit_data;

  assign idx_dec   = idx_r - itp_pkg::cnt_t'(1);
  assign sp_dec    = sp_r - itp_pkg::cnt_t'(1);
  assign in_ready  = ctrl.in_rdy;
  assign in_acc    = in_valid && ctrl.in_rdy;
  assign lb_we     = in_acc && (len_r < itp_pkg::LEN_MAX);
  assign stk_push  = ctrl.stk_we && (sp_r < itp_pkg::LEN_MAX);
  assign ob_push   = ctrl.ob_we && (olen_r < itp_pkg::LEN_MAX);
  assign emit_data = (ctrl.emit_src == itp_pkg::EMIT_CH) ? ch_r : stk_rdata;

  itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::LINE_LEN)) u_line_ram (
    .clk   (clk),
    .we    (lb_we),
    .waddr (len_r[itp_pkg::AW-1:0]),
    .wdata (in_data.char_in),
    .re    (ctrl.lb_re),
    .raddr (idx_dec[itp_pkg::AW-1:0]),
    .rdata (lb_rdata)
  );

  itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::LINE_LEN)) u_stack_ram (
    .clk   (clk),
    .we    (stk_push),
    .waddr (sp_r[itp_pkg::AW-1:0]),
    .wdata (ch_r),
    .re    (ctrl.stk_re),
    .raddr (sp_dec[itp_pkg::AW-1:0]),
    .rdata (stk_rdata)
  );

  itp_ram #(.WIDTH(8), .DEPTH(itp_pkg::LINE_LEN)) u_out_ram (
    .clk   (clk),
    .we    (ob_push),
    .waddr (olen_r[itp_pkg::AW-1:0]),
    .wdata (emit_data),
    .re    (ctrl.ob_re),
    .raddr (idx_dec[itp_pkg::AW-1:0]),
    .rdata (ob_rdata)
  );

  always_comb begin
    flags.last_in   = in_valid && in_data.is_last;
    flags.err_nz    = (err_r != itp_pkg::E_OK);
    flags.idx_zero  = (idx_r == '0);
    flags.sp_zero   = (sp_r == '0);
    flags.lb_open   = (lb_rdata == itp_pkg::CH_LPAREN);
    flags.lb_op     = itp_pkg::is_op(lb_rdata);
    flags.lb_alnum  = itp_pkg::is_alnum(lb_rdata);
    flags.lb_close  = (lb_rdata == itp_pkg::CH_RPAREN);
    flags.stk_close = (stk_rdata == itp_pkg::CH_RPAREN);
    flags.higher    = (itp_pkg::prec(stk_rdata) > itp_pkg::prec(ch_r));
    flags.olen_zero = (olen_r == '0);
    flags.out_busy  = out_valid_r && !out_ready;
  end

  always_comb begin
    len_nxt  = len_r;
    ovf_nxt  = ovf_r;
    idx_nxt  = idx_r;
    sp_nxt   = sp_r;
    olen_nxt = olen_r;
    ch_nxt   = ch_r;
    err_nxt  = err_r;

    if (in_acc) begin
      if (len_r < itp_pkg::LEN_MAX) begin
        len_nxt = len_r + itp_pkg::cnt_t'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    if (ctrl.init) begin
      len_nxt  = '0;
      ovf_nxt  = 1'b0;
      sp_nxt   = '0;
      olen_nxt = '0;
      err_nxt  = ovf_r ? itp_pkg::E_LONG : itp_pkg::E_OK;
    end

    case (ctrl.idx_op)
      itp_pkg::IDX_LEN:  idx_nxt = len_r;
      itp_pkg::IDX_DEC:  idx_nxt = idx_dec;
      itp_pkg::IDX_OLEN: idx_nxt = olen_r;
      default:           idx_nxt = idx_r;
    endcase

    case (ctrl.sp_op)
      itp_pkg::SP_DEC: sp_nxt = sp_dec;
      itp_pkg::SP_INC: begin
        if (sp_r < itp_pkg::LEN_MAX) begin
          sp_nxt = sp_r + itp_pkg::cnt_t'(1);
        end
      end
      default: ;
    endcase

    if (ob_push) begin
      olen_nxt = olen_r + itp_pkg::cnt_t'(1);
    end

    if (ctrl.ch_ld) begin
      ch_nxt = lb_rdata;
    end

    case (ctrl.err_op)
      itp_pkg::EOP_OPEN:  err_nxt = itp_pkg::E_OPEN;
      itp_pkg::EOP_CLOSE: err_nxt = itp_pkg::E_CLOSE;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.put_ok) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.char_out  = ob_rdata;
      out_data_nxt.last_out  = (idx_r == '0);
      out_data_nxt.empty_res = 1'b0;
      out_data_nxt.error     = itp_pkg::E_OK;
    end else if (ctrl.put_err) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.char_out  = 8'h00;
      out_data_nxt.last_out  = 1'b1;
      out_data_nxt.empty_res = 1'b1;
      out_data_nxt.error     = err_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      sp_r        <= '0;
      olen_r      <= '0;
      err_r       <= itp_pkg::E_OK;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      sp_r        <= sp_nxt;
      olen_r      <= olen_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
